@@ design/rlm_pkg.sv @@
package rlm_pkg;

  localparam int LINE_PIXELS   = 240;
  localparam int TOP_ROWS      = 48;
  localparam int MARGIN_PIXELS = 64;

  // Line length used for packing: whole words only, at least one word.
  localparam int LINE_LEN  = ((LINE_PIXELS / 4) * 4 < 4) ? 4 : (LINE_PIXELS / 4) * 4;
  localparam int BOT_START = (LINE_LEN > MARGIN_PIXELS) ? LINE_LEN - MARGIN_PIXELS : 0;

  localparam int COL_W = $clog2(LINE_LEN + 1);
  localparam int CMP_W = $clog2(LINE_LEN + MARGIN_PIXELS + 8) + 1;
  localparam int RUN_W = 8;
  localparam int ROW_W = 8;
  localparam int PIX_W = 16;
  localparam int WORD_PIX = 4;
  localparam int WORD_W = PIX_W * WORD_PIX;
  localparam int PROG_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [PIX_W-1:0] FG_BLUE  = 16'h033f;
  localparam logic [PIX_W-1:0] FG_WHITE = 16'hffff;
  localparam logic [ROW_W-1:0] WHITE_ROW_BASE = 8'd165;
  localparam logic [PROG_W-1:0] FULL_PERCENT = 7'd100;
  localparam logic [ROW_W-1:0] ROW_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_PROGRESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_CLIP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_CLIP = 2'd2;

  typedef struct packed {
    logic [RUN_W-1:0] run_length;
    logic             start_image;
  } rlm_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] pixel_word;
    logic [ROW_W-1:0]  row;
    logic              end_of_line;
    logic              last_of_run;
  } rlm_out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } rlm_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic can_step;
  } rlm_sts_t;

endpackage

@@ design/rlm_ctrl.sv @@
module rlm_ctrl
  import rlm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rlm_sts_t sts_i,
  output rlm_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } rlm_state_e;

  rlm_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        // Once all pixels of the run are out, the color toggles and the run ends.
        if (sts_i.rem_zero) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.step = sts_i.can_step;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_step_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> sts_i.can_step)
    else $error("step issued while the output register is blocked");

  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (state_q == ST_IDLE))
    else $error("controller did not return to idle after a run");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

endmodule

@@ design/rlm_dp.sv @@
module rlm_dp
  import rlm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PROG_W-1:0]    cfg_data_i,
  input  rlm_in_t              in_data_i,
  input  rlm_cmd_t             cmd_i,
  output rlm_sts_t             sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rlm_out_t             out_data_o
);

  logic [PROG_W-1:0] progress_q;
  logic              top_clip_q;
  logic              bot_clip_q;

  logic [COL_W-1:0]          col_q;
  logic [ROW_W-1:0]          row_q;
  logic [PIX_W-1:0]          cur_q;
  logic [PIX_W-1:0]          fg_q;
  logic [WORD_W-PIX_W-1:0]   partial_q;
  logic [1:0]                fill_q;
  logic [RUN_W-1:0]          rem_q;
  logic                      out_valid_q;
  rlm_out_t                  out_q;

  logic [2:0]        space;
  logic [2:0]        n;
  logic              complete;
  logic              eol;
  logic [WORD_W-1:0] acc;
  logic [RUN_W-1:0]  rem_after;
  logic [ROW_W-1:0]  white_row;
  logic [CMP_W-1:0]  col_end;

  // Up to four pixels per cycle while the output is not stalled, never past the end of the current word.
  always_comb begin
    logic [CMP_W-1:0] colk;
    logic [PIX_W-1:0] px;
    logic             blank;
    space = 3'd4 - {1'b0, fill_q};
    n = (rem_q < RUN_W'(space)) ? rem_q[2:0] : space;
    complete = (n == space);
    col_end = CMP_W'(col_q) + CMP_W'(n);
    eol = (col_end == CMP_W'(LINE_LEN));
    rem_after = rem_q - RUN_W'(n);
    acc = {{PIX_W{1'b0}}, partial_q};
    for (int k = 0; k < WORD_PIX; k++) begin
      colk = CMP_W'(col_q) + CMP_W'(k);
      blank = 1'b0;
      if (top_clip_q && ((row_q < ROW_W'(TOP_ROWS)) || (colk < CMP_W'(MARGIN_PIXELS)))) begin
        blank = 1'b1;
      end
      if (bot_clip_q && (colk >= CMP_W'(BOT_START))) begin
        blank = 1'b1;
      end
      px = blank ? '0 : cur_q;
      if (3'(k) < n) begin
        acc = {acc[WORD_W-PIX_W-1:0], px};
      end
    end
  end

  assign white_row = WHITE_ROW_BASE - ROW_W'(progress_q);

  assign sts_o.rem_zero = (rem_q == '0);
  assign sts_o.can_step = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      progress_q <= '0;
      top_clip_q <= 1'b1;
      bot_clip_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROGRESS:    progress_q <= cfg_data_i;
        CFG_TOP_CLIP:    top_clip_q <= cfg_data_i[0];
        CFG_BOTTOM_CLIP: bot_clip_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cur_q <= '0;
      fg_q <= FG_BLUE;
      partial_q <= '0;
      fill_q <= '0;
      rem_q <= '0;
    end else begin
      if (cmd_i.load) begin
        rem_q <= in_data_i.run_length;
        if (in_data_i.start_image) begin
          col_q <= '0;
          row_q <= '0;
          cur_q <= '0;
          partial_q <= '0;
          fill_q <= '0;
          fg_q <= (progress_q < FULL_PERCENT) ? FG_BLUE : FG_WHITE;
        end
      end
      if (cmd_i.step) begin
        rem_q <= rem_after;
        partial_q <= complete ? '0 : acc[WORD_W-PIX_W-1:0];
        fill_q <= complete ? 2'd0 : 2'(fill_q + n[1:0]);
        if (eol) begin
          col_q <= '0;
          if (row_q >= white_row) begin
            fg_q <= FG_WHITE;
          end
          if (row_q != ROW_MAX) begin
            row_q <= row_q + 1'b1;
          end
        end else begin
          col_q <= col_end[COL_W-1:0];
        end
      end
      if (cmd_i.finish) begin
        cur_q <= (cur_q == '0) ? fg_q : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step && complete) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && complete) begin
      out_q.pixel_word <= acc;
      out_q.row <= row_q;
      out_q.end_of_line <= eol;
      // No further word can complete from fewer than four pixels.
      out_q.last_of_run <= (rem_after < RUN_W'(WORD_PIX));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  a_fill_tracks_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == col_q[1:0])
    else $error("word fill out of step with column");

  a_col_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(col_q) < CMP_W'(LINE_LEN))
    else $error("column past end of line");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled output item changed or dropped");

endmodule

@@ design/rle_mono_image_to_rgb565_lines.sv @@
// Run-length decoder for a 1-bit image, producing RGB565 line words.
// Input channel (in_valid_i / in_stall_o / in_data_i): one item is a run
// length plus a start-of-image flag. Runs alternate background and
// foreground color; a zero-length run still toggles the color.
// Output channel (out_valid_o / out_stall_i / out_data_o): one item is a
// 64-bit word of four pixels, first pixel in the high bits, with its row,
// an end-of-line flag and a last-of-run flag. Runs that complete no word
// produce no output item.
// The block works on one run at a time: it accepts the run, steps once per
// word that the run touches, and then toggles the color; only after the
// toggle does it take the next run. A word becomes valid from the output
// register after the step that completes it.
// A finished word sits in an output register; while the receiver stalls,
// the datapath holds and the input stays stalled until the run is done.
// Reset clears position and color state, sets the foreground to blue,
// progress to 0 and both clip enables to 1. Configuration is written
// through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write it only
// while no run is in flight: the block itself does not enforce this.
module rle_mono_image_to_rgb565_lines
  import rlm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PROG_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rlm_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rlm_out_t             out_data_o
);

  rlm_cmd_t cmd;
  rlm_sts_t sts;

  rlm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rlm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sim/rgb565_line_checker.sv @@
module rgb565_line_checker
  import rlm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PROG_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  rlm_in_t              in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  rlm_out_t             out_data_i,
  output int                   mismatch_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the registers and of the decoder position.
  logic [PROG_W-1:0] progress_q;
  logic              top_clip_q;
  logic              bottom_clip_q;
  int unsigned       col_q;
  logic [ROW_W-1:0]  row_q;
  logic [PIX_W-1:0]  color_q;
  logic [PIX_W-1:0]  fg_q;
  logic [WORD_W-1:0] pack_q;
  int unsigned       fill_q;

  rlm_out_t line_words_q [$];
  int       mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches++;
  endtask

  // Expands one run into the words it completes and queues them.
  task automatic expand_run(input rlm_in_t item);
    rlm_out_t         words [64];
    rlm_out_t         w;
    int               n;
    int               i;
    logic [PIX_W-1:0] px;
    bit               eol;
    n = 0;
    if (item.start_image) begin
      col_q   = 0;
      row_q   = '0;
      pack_q  = '0;
      fill_q  = 0;
      color_q = '0;
      fg_q    = (progress_q < FULL_PERCENT) ? FG_BLUE : FG_WHITE;
    end
    for (i = 0; i < item.run_length; i++) begin
      px = color_q;
      if (col_q >= LINE_LEN) col_q = 0;
      if (top_clip_q && (row_q < TOP_ROWS || col_q < MARGIN_PIXELS)) px = '0;
      if (bottom_clip_q && col_q + MARGIN_PIXELS >= LINE_LEN) px = '0;
      pack_q = {pack_q[WORD_W-PIX_W-1:0], px};
      fill_q++;
      col_q++;
      eol = (col_q >= LINE_LEN);
      if (fill_q >= WORD_PIX) begin
        w.pixel_word  = pack_q;
        w.row         = row_q;
        w.end_of_line = eol;
        w.last_of_run = 1'b0;
        words[n]      = w;
        n++;
        pack_q = '0;
        fill_q = 0;
      end
      if (eol) begin
        // The new foreground only shows up after the next color toggle.
        if (int'(row_q) >= int'(WHITE_ROW_BASE) - int'(progress_q)) fg_q = FG_WHITE;
        col_q = 0;
        if (row_q != ROW_MAX) row_q++;
      end
    end
    if (n > 0) words[n-1].last_of_run = 1'b1;
    for (i = 0; i < n; i++) line_words_q.push_back(words[i]);
    color_q = (color_q == '0) ? fg_q : '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rlm_out_t want;
    if (!rst_ni) begin
      progress_q    = '0;
      top_clip_q    = 1'b1;
      bottom_clip_q = 1'b1;
      col_q         = 0;
      row_q         = '0;
      color_q       = '0;
      fg_q          = FG_BLUE;
      pack_q        = '0;
      fill_q        = 0;
      line_words_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PROGRESS:    progress_q = cfg_data_i;
          CFG_TOP_CLIP:    top_clip_q = cfg_data_i[0];
          CFG_BOTTOM_CLIP: bottom_clip_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expand_run(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (line_words_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected word %h row %0d",
                                  out_data_i.pixel_word, out_data_i.row));
        end else begin
          want = line_words_q.pop_front();
          if (out_data_i.pixel_word !== want.pixel_word)
            flag_mismatch($sformatf("pixel_word got %h expected %h",
                                    out_data_i.pixel_word, want.pixel_word));
          if (out_data_i.row !== want.row)
            flag_mismatch($sformatf("row got %0d expected %0d",
                                    out_data_i.row, want.row));
          if (out_data_i.end_of_line !== want.end_of_line)
            flag_mismatch($sformatf("end_of_line got %b expected %b",
                                    out_data_i.end_of_line, want.end_of_line));
          if (out_data_i.last_of_run !== want.last_of_run)
            flag_mismatch($sformatf("last_of_run got %b expected %b",
                                    out_data_i.last_of_run, want.last_of_run));
        end
      end
      pending_o <= line_words_q.size();
    end
  end

endmodule

@@ sim/rle_mono_image_to_rgb565_lines_test.sv @@
module rle_mono_image_to_rgb565_lines_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rlm_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_e;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int LONG_HOLD      = 400;
  localparam int NUM_PHASES     = 6;
  localparam int PRESSURE_PHASE = 2;
  localparam int LONG_PHASE     = 5;
  localparam int OPENING_ITEMS  = 20;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [PROG_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  rlm_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  rlm_out_t             out_data;
  int                   mismatch_count;
  int                   pending;

  idle_mode_e in_mode  = IDLE_NONE;
  idle_mode_e out_mode = IDLE_NONE;
  int         hold_len = 0;
  int         runs_sent = 0;
  int         images_started = 0;
  int         settings_used = 0;
  int         words_seen = 0;
  int         lines_seen = 0;

  // Zero runs, runs that complete no word, full-length runs and a restart
  // in the middle of an image.
  logic [RUN_W-1:0] opening_runs [OPENING_ITEMS] =
    '{0, 3, 0, 1, 255, 255, 254, 2, 128, 64, 7, 0, 0, 1, 255, 255, 170, 85, 240, 4};
  logic opening_starts [OPENING_ITEMS] =
    '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0};

  int   progress_plan [NUM_PHASES] = '{0, 50, 99, 100, 0, 1};
  logic top_plan [NUM_PHASES]      = '{1, 0, 1, 1, 0, 1};
  logic bottom_plan [NUM_PHASES]   = '{1, 1, 0, 1, 0, 1};

  rle_mono_image_to_rgb565_lines DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  rgb565_line_checker line_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      default:    return $urandom_range(0, 13);
    endcase
  endfunction

  task automatic send_run(input logic [RUN_W-1:0] run, input logic start);
    int gap;
    gap = draw_gap(in_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.run_length  <= run;
    in_data.start_image <= start;
    do @(posedge clk); while (in_stall);
    runs_sent++;
    if (start) images_started++;
  endtask

  // A run that completes no word gives no sign of being done, so the block
  // gets a little more than its longest run time before it counts as idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(input logic [PROG_W-1:0] progress, input logic top,
                               input logic bottom);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_PROGRESS;
    cfg_data <= progress;
    @(posedge clk);
    cfg_idx  <= CFG_TOP_CLIP;
    cfg_data <= {{(PROG_W-1){1'b0}}, top};
    @(posedge clk);
    cfg_idx  <= CFG_BOTTOM_CLIP;
    cfg_data <= {{(PROG_W-1){1'b0}}, bottom};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Receiver: a random stall before each item, plus one long hold on request.
  initial begin
    int hold;
    int stall_for;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = hold_len;
      hold_len = 0;
      stall_for = draw_gap(out_mode) + hold;
      if (stall_for > 0) begin
        out_stall <= 1'b1;
        repeat (stall_for) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (out_valid && !out_stall) begin
        words_seen++;
        if (out_data.end_of_line) lines_seen++;
      end
    end
    $display("Watchdog: no transfer for %0d cycles, %0d words outstanding",
             WATCHDOG_LIMIT, pending);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int               ph;
    int               k;
    int               n_items;
    int               pick;
    logic [RUN_W-1:0] run;
    logic             start;
    rst_n    = 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_PROGRESS;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Progress above 100 starts the image white; no clipping so colors show.
    set_registers(7'd127, 1'b0, 1'b0);
    for (k = 0; k < OPENING_ITEMS; k++) send_run(opening_runs[k], opening_starts[k]);

    progress_plan[4] = $urandom_range(0, 127);
    top_plan[4]      = 1'($urandom_range(0, 1));
    bottom_plan[4]   = 1'($urandom_range(0, 1));

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      set_registers(PROG_W'(progress_plan[ph]), top_plan[ph], bottom_plan[ph]);
      in_mode  = idle_mode_e'($urandom_range(0, 2));
      out_mode = idle_mode_e'($urandom_range(0, 2));
      if (ph == 0) begin
        in_mode  = IDLE_NONE;
        out_mode = IDLE_NONE;
      end
      if (ph == PRESSURE_PHASE) begin
        in_mode  = IDLE_NONE;
        hold_len = LONG_HOLD;
      end
      // The long image runs past row 255 and past the white-foreground row.
      n_items = (ph == LONG_PHASE) ? 280 : 12;
      for (k = 0; k < n_items; k++) begin
        pick = $urandom_range(0, 9);
        if (ph == LONG_PHASE)
          run = (pick == 0) ? RUN_W'($urandom_range(0, 255)) : RUN_W'($urandom_range(230, 255));
        else if (pick < 3)
          run = RUN_W'($urandom_range(0, 7));
        else if (pick < 6)
          run = RUN_W'($urandom_range(200, 255));
        else
          run = RUN_W'($urandom_range(0, 255));
        if (k == 0)
          start = (ph == LONG_PHASE) ? 1'b1 : 1'($urandom_range(0, 1));
        else
          start = (ph != LONG_PHASE) && ($urandom_range(0, 29) == 0);
        send_run(run, start);
      end
    end

    wait_idle();
    $display("Covered %0d runs in %0d images under %0d settings; %0d words, %0d line ends.",
             runs_sent, images_started, settings_used, words_seen, lines_seen);
    $display("A %0d-cycle receiver hold backed up the input; %0d mismatches.",
             LONG_HOLD, mismatch_count);
    if (mismatch_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
design/rlm_pkg.sv
design/rlm_ctrl.sv
design/rlm_dp.sv
design/rle_mono_image_to_rgb565_lines.sv
sim/rgb565_line_checker.sv
sim/rle_mono_image_to_rgb565_lines_test.sv
